@@ rtl/core/outstanding_request_tracker_defines.svh @@
// Assertion macros for the outstanding request tracker.
// Included by files that check their own logic; depends on nothing else.
`ifndef OUTSTANDING_REQUEST_TRACKER_DEFINES_SVH
`define OUTSTANDING_REQUEST_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge out of reset.
`define ORT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked on every rising clock edge out of reset.
`define ORT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);
`else
`define ORT_ASSERT_NOW(lbl, ante, cons, msg)
`define ORT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/core/ort_pkg.sv @@
// Shared types and constants of the outstanding request tracker.
// Used by ort_cell and outstanding_request_tracker; depends on nothing.
package ort_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int MAX_OUT   = 8;
    localparam int CNT_W     = $clog2(MAX_OUT + 1);
    localparam int SLOT_W    = 3;

    localparam logic [1:0] CMD_ISSUE    = 2'd0;
    localparam logic [1:0] CMD_TICK     = 2'd1;
    localparam logic [1:0] CMD_REPLY    = 2'd2;
    localparam logic [1:0] CMD_COMPLETE = 2'd3;

    localparam logic [2:0] ST_ISSUED     = 3'd0;
    localparam logic [2:0] ST_NO_SLOT    = 3'd1;
    localparam logic [2:0] ST_MATCHED    = 3'd2;
    localparam logic [2:0] ST_UNEXPECTED = 3'd3;
    localparam logic [2:0] ST_TIMED_OUT  = 3'd4;
    localparam logic [2:0] ST_COMPLETED  = 3'd5;
    localparam logic [2:0] ST_STALE      = 3'd6;

    typedef struct packed {
        logic [1:0]        command;
        logic [29:0]       timeout_ms;
        logic              is_channel;
        logic [31:0]       reply_tag;
        logic [SLOT_W-1:0] slot_select;
    } t_cmd_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot_index;
        logic [31:0]       reply_id_out;
        logic              channel_flag;
        logic              last;
    } t_result;

    // Operands of the command being worked, broadcast to every cell.
    typedef struct packed {
        logic [1:0]        cmd;
        logic [31:0]       now;
        logic [31:0]       tag_new;
        logic [31:0]       deadline;
        logic              chan;
        logic [31:0]       rtag;
        logic [SLOT_W-1:0] sel;
    } t_op;

    // Token that walks the cell row, one cell per cycle.
    typedef struct packed {
        logic             valid;
        logic             done;
        logic [CNT_W-1:0] count;
    } t_probe;

    // Report of the cell that acted on the token; all zero when idle.
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       tag;
        logic              chan;
    } t_hit;

endpackage

@@ rtl/core/ort_cell.sv @@
// One slot of the request table: holds the slot state and acts when the token passes.
// Depends on ort_pkg.
module ort_cell #(
    parameter int INDEX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ort_pkg::t_op    i_op,
    input  ort_pkg::t_probe i_probe,
    output ort_pkg::t_probe o_probe,
    output ort_pkg::t_hit   o_hit
);

    logic            r_busy, n_busy;
    logic            r_queued, n_queued;
    logic [31:0]     r_tag, n_tag;
    logic [31:0]     r_deadline, n_deadline;
    logic            r_chan, n_chan;
    ort_pkg::t_probe r_probe, n_probe;
    ort_pkg::t_hit   r_hit, n_hit;
    logic [31:0]     w_diff;
    logic            w_late;

    // Past the deadline when the modular distance lies in the lower half, excluding zero.
    assign w_diff = i_op.now - r_deadline;
    assign w_late = (w_diff != 32'd0) && !w_diff[31];

    always_comb begin
        n_busy     = r_busy;
        n_queued   = r_queued;
        n_tag      = r_tag;
        n_deadline = r_deadline;
        n_chan     = r_chan;
        n_probe    = i_probe;
        n_hit      = '0;
        if (i_probe.valid) begin
            case (i_op.cmd)
                ort_pkg::CMD_ISSUE: begin
                    if (!i_probe.done && !r_busy) begin
                        n_busy       = 1'b1;
                        n_queued     = 1'b0;
                        n_tag        = i_op.tag_new;
                        n_deadline   = i_op.deadline;
                        n_chan       = i_op.chan;
                        n_probe.done = 1'b1;
                        n_hit        = '{valid: 1'b1, slot: ort_pkg::SLOT_W'(INDEX),
                                         tag: i_op.tag_new, chan: i_op.chan};
                    end
                end
                ort_pkg::CMD_TICK: begin
                    if (r_busy && !r_queued && w_late &&
                        i_probe.count < ort_pkg::CNT_W'(ort_pkg::MAX_OUT)) begin
                        n_busy        = 1'b0;
                        n_probe.count = i_probe.count + ort_pkg::CNT_W'(1);
                        n_hit         = '{valid: 1'b1, slot: ort_pkg::SLOT_W'(INDEX),
                                          tag: r_tag, chan: r_chan};
                    end
                end
                ort_pkg::CMD_REPLY: begin
                    if (!i_probe.done && r_busy && r_tag == i_op.rtag) begin
                        n_queued     = 1'b1;
                        n_probe.done = 1'b1;
                        n_hit        = '{valid: 1'b1, slot: ort_pkg::SLOT_W'(INDEX),
                                         tag: r_tag, chan: r_chan};
                    end
                end
                ort_pkg::CMD_COMPLETE: begin
                    if (r_busy && INDEX == int'(i_op.sel)) begin
                        n_busy       = 1'b0;
                        n_queued     = 1'b0;
                        n_probe.done = 1'b1;
                        n_hit        = '{valid: 1'b1, slot: ort_pkg::SLOT_W'(INDEX),
                                         tag: r_tag, chan: r_chan};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_queued <= 1'b0;
            r_probe  <= '0;
            r_hit    <= '0;
        end else begin
            r_busy   <= n_busy;
            r_queued <= n_queued;
            r_probe  <= n_probe;
            r_hit    <= n_hit;
        end
    end

    // Slot payload is only read while the slot is busy, so it needs no reset.
    always_ff @(posedge i_clk) begin
        r_tag      <= n_tag;
        r_deadline <= n_deadline;
        r_chan     <= n_chan;
    end

    assign o_probe = r_probe;
    assign o_hit   = r_hit;

endmodule

@@ rtl/core/outstanding_request_tracker.sv @@
// Outstanding request tracker: a row of slot cells walked by a token, plus command control.
// Depends on ort_pkg, ort_cell and outstanding_request_tracker_defines.svh.
//
// A command is taken when start is high and busy is low; busy then stays high while a
// token walks the row of slot cells, one cell per cycle, so no new command is taken
// until the sweep is over and busy falls. Issue, reply and completion give one result,
// in the cycle that busy falls. A tick gives one result per expired slot, up to eight,
// lowest slot first, the last marked by last; a tick that expires nothing gives none.
// Each result is shown for one cycle with o_result_valid and cannot be held off, so the
// receiver must take it then.
`include "outstanding_request_tracker_defines.svh"

module outstanding_request_tracker #(
    parameter int SLOTS = ort_pkg::SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  ort_pkg::t_cmd_item i_cmd,
    output logic               busy,
    output logic               o_result_valid,
    output ort_pkg::t_result   o_result
);

    logic                r_busy, n_busy;
    logic                r_fin, n_fin;
    logic [31:0]         r_now, n_now;
    logic [31:0]         r_tag, n_tag;
    ort_pkg::t_op        r_op, n_op;
    ort_pkg::t_probe     r_probe, n_probe;
    logic                r_pend_v, n_pend_v;
    ort_pkg::t_result    r_pend, n_pend;
    logic                r_out_v, n_out_v;
    ort_pkg::t_result    r_out, n_out;

    ort_pkg::t_probe     w_probe [SLOTS+1];
    ort_pkg::t_hit       w_hits  [SLOTS];
    ort_pkg::t_hit       w_hit;
    logic [SLOTS-1:0]    w_hit_vec;
    ort_pkg::t_probe     w_end;
    logic [31:0]         w_tag_inc;
    logic [31:0]         w_tag_new;
    logic                w_accept;
    logic [2:0]          w_hit_status;
    logic                w_want_result;

    assign w_accept  = start && !r_busy;
    assign w_tag_inc = r_tag + 32'd1;
    assign w_tag_new = (w_tag_inc == 32'd0) ? 32'd1 : w_tag_inc;

    assign w_probe[0] = r_probe;
    assign w_end      = w_probe[SLOTS];

    assign w_want_result = w_end.valid && (r_op.cmd != ort_pkg::CMD_TICK);

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        ort_cell #(
            .INDEX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_op   (r_op),
            .i_probe(w_probe[g]),
            .o_probe(w_probe[g+1]),
            .o_hit  (w_hits[g])
        );
        assign w_hit_vec[g] = w_hits[g].valid;
    end

    // Only the cell holding the token can report, so the reports merge by OR.
    always_comb begin
        w_hit = '0;
        for (int i = 0; i < SLOTS; i++) begin
            w_hit = ort_pkg::t_hit'(w_hit | w_hits[i]);
        end
    end

    always_comb begin
        case (r_op.cmd)
            ort_pkg::CMD_ISSUE:    w_hit_status = ort_pkg::ST_ISSUED;
            ort_pkg::CMD_TICK:     w_hit_status = ort_pkg::ST_TIMED_OUT;
            ort_pkg::CMD_REPLY:    w_hit_status = ort_pkg::ST_MATCHED;
            ort_pkg::CMD_COMPLETE: w_hit_status = ort_pkg::ST_COMPLETED;
            default:               w_hit_status = ort_pkg::ST_STALE;
        endcase
    end

    // A result waits in the pending register until the next one arrives or the sweep
    // ends, which is what decides its last flag.
    always_comb begin
        n_busy   = r_busy;
        n_fin    = w_end.valid;
        n_now    = r_now;
        n_tag    = r_tag;
        n_op     = r_op;
        n_probe  = '0;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_out_v  = 1'b0;
        n_out    = r_out;

        if (w_accept) begin
            n_busy  = 1'b1;
            n_probe = '{valid: 1'b1, done: 1'b0, count: '0};
            n_op    = '{cmd: i_cmd.command, now: r_now + 32'd1, tag_new: w_tag_new,
                        deadline: r_now + 32'(i_cmd.timeout_ms), chan: i_cmd.is_channel,
                        rtag: i_cmd.reply_tag, sel: i_cmd.slot_select};
            if (i_cmd.command == ort_pkg::CMD_TICK) begin
                n_now = r_now + 32'd1;
            end
        end

        if (w_hit.valid) begin
            if (r_pend_v) begin
                n_out_v = 1'b1;
                n_out   = r_pend;
            end
            n_pend_v = 1'b1;
            n_pend   = '{status: w_hit_status, slot_index: w_hit.slot,
                         reply_id_out: w_hit.tag, channel_flag: w_hit.chan,
                         last: 1'b0};
        end

        if (w_end.valid) begin
            if (w_end.done) begin
                if (r_op.cmd == ort_pkg::CMD_ISSUE) begin
                    n_tag = r_op.tag_new;
                end
            end else begin
                case (r_op.cmd)
                    ort_pkg::CMD_ISSUE: begin
                        n_pend_v = 1'b1;
                        n_pend   = '{status: ort_pkg::ST_NO_SLOT, default: '0};
                    end
                    ort_pkg::CMD_REPLY: begin
                        n_pend_v = 1'b1;
                        n_pend   = '{status: ort_pkg::ST_UNEXPECTED, default: '0};
                    end
                    ort_pkg::CMD_COMPLETE: begin
                        n_pend_v = 1'b1;
                        n_pend   = '{status: ort_pkg::ST_STALE, slot_index: r_op.sel,
                                     default: '0};
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (r_fin) begin
            n_busy   = 1'b0;
            n_pend_v = 1'b0;
            if (r_pend_v) begin
                n_out_v  = 1'b1;
                n_out    = r_pend;
                n_out.last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_fin    <= 1'b0;
            r_now    <= 32'd0;
            r_tag    <= 32'd0;
            r_probe  <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_fin    <= n_fin;
            r_now    <= n_now;
            r_tag    <= n_tag;
            r_probe  <= n_probe;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign busy           = r_busy;
    assign o_result_valid = r_out_v;
    assign o_result       = r_out;

    `ORT_ASSERT_NOW(a_one_reporter, 1'b1, $onehot0(w_hit_vec), "two cells reported at once")
    `ORT_ASSERT_NOW(a_result_in_work, o_result_valid, $past(r_busy), "result beat while idle")
    `ORT_ASSERT_NOW(a_idle_no_pending, !r_busy, !r_pend_v, "pending result left when idle")
    `ORT_ASSERT_NEXT(a_single_result, w_want_result, r_pend_v, "command ended without a result")

endmodule

@@ dv/outstanding_request_tracker_test.sv @@
// Self-checking testbench of outstanding_request_tracker: a directed table, then random commands.
// Depends on ort_pkg and the block RTL; an in-bench slot table predicts all untyped results.
module outstanding_request_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ort_pkg::*;

    localparam int SLOTS      = SLOTS_DEF;
    localparam int RANDOM_CMD = 160;
    localparam int IDLE_LIMIT = 1000;

    typedef struct {
        t_cmd_item item;
        bit        typed;
        t_result   want;
    } t_plan_row;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_cmd_item i_cmd   = '0;
    logic      busy;
    logic      o_result_valid;
    t_result   o_result;

    // Predicted slot table.
    logic        trk_busy     [SLOTS];
    logic [31:0] trk_tag      [SLOTS];
    logic [31:0] trk_deadline [SLOTS];
    logic        trk_queued   [SLOTS];
    logic        trk_chan     [SLOTS];
    logic [31:0] trk_tag_count;
    logic [31:0] trk_now;

    t_result   pending_results[$];
    t_plan_row plan[$];
    t_result   want_now;
    int        mismatches       = 0;
    int        accepted_cmds    = 0;
    int        results_checked  = 0;
    int        timeouts_expected = 0;
    int        burst_left       = 4;
    int        idle_cycles      = 0;

    outstanding_request_tracker dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_cmd          (i_cmd),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_cmd_item cmd_item(logic [1:0] command, logic [29:0] timeout_ms,
                                           logic is_channel, logic [31:0] reply_tag,
                                           logic [2:0] slot_select);
        t_cmd_item c;
        c.command     = command;
        c.timeout_ms  = timeout_ms;
        c.is_channel  = is_channel;
        c.reply_tag   = reply_tag;
        c.slot_select = slot_select;
        return c;
    endfunction

    task automatic add_row(input t_cmd_item item, input bit typed, input t_result want);
        t_plan_row row;
        row.item  = item;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    // Applies one command to the slot table and, if asked, queues the results it causes.
    task automatic predict_command(input t_cmd_item c, input bit record);
        int          found;
        int          hits[$];
        logic [31:0] age;
        t_result     r;
        found = -1;
        case (c.command)
            CMD_ISSUE: begin
                for (int s = 0; s < SLOTS; s++)
                    if (!trk_busy[s] && found < 0) found = s;
                if (found < 0) begin
                    r = '{ST_NO_SLOT, 3'd0, 32'd0, 1'b0, 1'b1};
                end else begin
                    trk_tag_count = trk_tag_count + 32'd1;
                    if (trk_tag_count == 32'd0) trk_tag_count = 32'd1;
                    trk_busy[found]     = 1'b1;
                    trk_tag[found]      = trk_tag_count;
                    trk_deadline[found] = trk_now + {2'b00, c.timeout_ms};
                    trk_queued[found]   = 1'b0;
                    trk_chan[found]     = c.is_channel;
                    r = '{ST_ISSUED, 3'(found), trk_tag_count, c.is_channel, 1'b1};
                end
                if (record) pending_results.push_back(r);
            end
            CMD_TICK: begin
                trk_now = trk_now + 32'd1;
                // Past the deadline means a nonzero age in the lower half of the 32-bit circle.
                for (int s = 0; s < SLOTS; s++) begin
                    age = trk_now - trk_deadline[s];
                    if (trk_busy[s] && !trk_queued[s] && age != 32'd0 && !age[31]
                            && hits.size() < MAX_OUT)
                        hits.push_back(s);
                end
                foreach (hits[k]) begin
                    r = '{ST_TIMED_OUT, 3'(hits[k]), trk_tag[hits[k]], trk_chan[hits[k]],
                          (k == hits.size() - 1)};
                    if (record) pending_results.push_back(r);
                    trk_busy[hits[k]] = 1'b0;
                    trk_tag[hits[k]]  = 32'd0;
                end
                timeouts_expected += hits.size();
            end
            CMD_REPLY: begin
                for (int s = 0; s < SLOTS; s++)
                    if (trk_busy[s] && trk_tag[s] == c.reply_tag && found < 0) found = s;
                if (found < 0) begin
                    r = '{ST_UNEXPECTED, 3'd0, 32'd0, 1'b0, 1'b1};
                end else begin
                    trk_queued[found] = 1'b1;
                    r = '{ST_MATCHED, 3'(found), trk_tag[found], trk_chan[found], 1'b1};
                end
                if (record) pending_results.push_back(r);
            end
            CMD_COMPLETE: begin
                if (int'(c.slot_select) >= SLOTS || !trk_busy[c.slot_select]) begin
                    r = '{ST_STALE, c.slot_select, 32'd0, 1'b0, 1'b1};
                end else begin
                    found = int'(c.slot_select);
                    r = '{ST_COMPLETED, 3'(found), trk_tag[found], trk_chan[found], 1'b1};
                    trk_busy[found]   = 1'b0;
                    trk_queued[found] = 1'b0;
                    trk_tag[found]    = 32'd0;
                end
                if (record) pending_results.push_back(r);
            end
        endcase
    endtask

    // Random command: mostly live tags and busy slots, so requests run their whole life.
    function automatic t_cmd_item make_random_command();
        t_cmd_item c;
        int        live[$];
        int        pick;
        for (int s = 0; s < SLOTS; s++)
            if (trk_busy[s]) live.push_back(s);
        c.timeout_ms  = 30'($urandom);
        c.is_channel  = 1'($urandom);
        c.reply_tag   = $urandom;
        c.slot_select = 3'($urandom);
        pick = $urandom_range(0, 9);
        if (pick <= 2) begin
            c.command = CMD_ISSUE;
            if ($urandom_range(0, 7) != 0) c.timeout_ms = 30'($urandom_range(0, 5));
        end else if (pick <= 5) begin
            c.command = CMD_TICK;
        end else if (pick <= 7) begin
            c.command = CMD_REPLY;
            pick = $urandom_range(0, 9);
            if (live.size() > 0 && pick <= 6)
                c.reply_tag = trk_tag[live[$urandom_range(0, live.size() - 1)]];
            else if (pick == 7)
                c.reply_tag = trk_tag_count - 32'($urandom_range(0, 3));
            else if (pick == 8)
                c.reply_tag = 32'd0;
        end else begin
            c.command = CMD_COMPLETE;
            if (live.size() > 0 && $urandom_range(0, 3) != 0)
                c.slot_select = 3'(live[$urandom_range(0, live.size() - 1)]);
        end
        return c;
    endfunction

    // One command beat; the sender then either keeps start high or idles for a gap, draining first if asked.
    task automatic drive_command(input t_cmd_item item, input bit typed, input t_result want,
                                 input bit final_beat, input bit drain);
        start <= 1'b1;
        i_cmd <= item;
        do @(posedge i_clk); while (busy);
        accepted_cmds++;
        predict_command(item, !typed);
        if (typed) pending_results.push_back(want);
        burst_left--;
        if (final_beat || drain || burst_left <= 0) begin
            start <= 1'b0;
            if (drain)
                while (pending_results.size() != 0) @(posedge i_clk);
            if (!final_beat) repeat ($urandom_range(1, 14)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
        end
    endtask

    function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
            $display("%0t ns: %s expected 0x%0h got 0x%0h", $time, name, want, got);
        return got === want;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result %p", $time, o_result);
                mismatches++;
            end else begin
                want_now = pending_results.pop_front();
                if (!field_ok("status", 32'(want_now.status), 32'(o_result.status)))
                    mismatches++;
                if (!field_ok("slot_index", 32'(want_now.slot_index), 32'(o_result.slot_index)))
                    mismatches++;
                if (!field_ok("reply_id_out", want_now.reply_id_out, o_result.reply_id_out))
                    mismatches++;
                if (!field_ok("channel_flag", 32'(want_now.channel_flag),
                              32'(o_result.channel_flag)))
                    mismatches++;
                if (!field_ok("last", 32'(want_now.last), 32'(o_result.last)))
                    mismatches++;
            end
        end
    end

    // Watchdog on cycles with neither an accepted command nor a result.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t ns: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("outstanding_request_tracker: mismatch");
                $finish;
            end
        end
    end

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            trk_busy[s]     = 1'b0;
            trk_tag[s]      = 32'd0;
            trk_deadline[s] = 32'd0;
            trk_queued[s]   = 1'b0;
            trk_chan[s]     = 1'b0;
        end
        trk_tag_count = 32'd0;
        trk_now       = 32'd0;

        // Empty table: replies and completions find nothing.
        add_row(cmd_item(CMD_REPLY, 30'd0, 1'b0, 32'd0, 3'd0), 1'b1,
                '{ST_UNEXPECTED, 3'd0, 32'd0, 1'b0, 1'b1});
        add_row(cmd_item(CMD_COMPLETE, 30'd0, 1'b0, 32'd0, 3'd0), 1'b1,
                '{ST_STALE, 3'd0, 32'd0, 1'b0, 1'b1});
        add_row(cmd_item(CMD_COMPLETE, 30'h3FFFFFFF, 1'b1, 32'hFFFFFFFF, 3'd7), 1'b1,
                '{ST_STALE, 3'd7, 32'd0, 1'b0, 1'b1});
        // Fill every slot with a zero timeout so that one tick expires all eight.
        add_row(cmd_item(CMD_ISSUE, 30'd0, 1'b1, 32'd0, 3'd0), 1'b1,
                '{ST_ISSUED, 3'd0, 32'd1, 1'b1, 1'b1});
        for (int k = 1; k < SLOTS; k++)
            add_row(cmd_item(CMD_ISSUE, 30'd0, 1'(k), 32'd0, 3'd0), 1'b0, '0);
        add_row(cmd_item(CMD_ISSUE, 30'd7, 1'b1, 32'd0, 3'd0), 1'b1,
                '{ST_NO_SLOT, 3'd0, 32'd0, 1'b0, 1'b1});
        add_row(cmd_item(CMD_TICK, 30'd0, 1'b0, 32'd0, 3'd0), 1'b0, '0);
        // Nothing left to expire: this tick is quiet.
        add_row(cmd_item(CMD_TICK, 30'd0, 1'b0, 32'd0, 3'd0), 1'b0, '0);
        add_row(cmd_item(CMD_ISSUE, 30'h3FFFFFFF, 1'b1, 32'd0, 3'd0), 1'b1,
                '{ST_ISSUED, 3'd0, 32'd9, 1'b1, 1'b1});
        add_row(cmd_item(CMD_ISSUE, 30'd0, 1'b0, 32'd0, 3'd0), 1'b0, '0);
        add_row(cmd_item(CMD_REPLY, 30'd0, 1'b0, 32'd9, 3'd0), 1'b0, '0);
        add_row(cmd_item(CMD_REPLY, 30'd0, 1'b0, 32'd9, 3'd0), 1'b0, '0);
        add_row(cmd_item(CMD_REPLY, 30'd0, 1'b0, 32'hFFFFFFFF, 3'd0), 1'b1,
                '{ST_UNEXPECTED, 3'd0, 32'd0, 1'b0, 1'b1});
        // Slot 1 was never answered; it is freed all the same.
        add_row(cmd_item(CMD_COMPLETE, 30'd0, 1'b0, 32'd0, 3'd1), 1'b0, '0);
        add_row(cmd_item(CMD_COMPLETE, 30'd0, 1'b0, 32'd0, 3'd1), 1'b1,
                '{ST_STALE, 3'd1, 32'd0, 1'b0, 1'b1});
        // Slot 0 is queued and far from its deadline, so this tick expires nothing before it is completed.
        add_row(cmd_item(CMD_TICK, 30'd0, 1'b0, 32'd0, 3'd0), 1'b0, '0);
        add_row(cmd_item(CMD_COMPLETE, 30'd0, 1'b0, 32'd0, 3'd0), 1'b0, '0);
        add_row(cmd_item(CMD_ISSUE, 30'd1, 1'b0, 32'd0, 3'd0), 1'b0, '0);
        add_row(cmd_item(CMD_TICK, 30'd0, 1'b0, 32'd0, 3'd0), 1'b0, '0);
        add_row(cmd_item(CMD_TICK, 30'd0, 1'b0, 32'd0, 3'd0), 1'b0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i])
            drive_command(plan[i].item, plan[i].typed, plan[i].want, 1'b0, 1'b0);
        for (int n = 0; n < RANDOM_CMD; n++)
            drive_command(make_random_command(), 1'b0, '0, n == RANDOM_CMD - 1,
                          n == RANDOM_CMD / 2);

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SLOTS + 8) @(posedge i_clk);

        $display("Ran %0d commands (%0d directed), checked %0d results, %0d of them timeouts.",
                 accepted_cmds, plan.size(), results_checked, timeouts_expected);
        $display("Covered issue, full table, replies, completions, stale ids and quiet ticks.");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("outstanding_request_tracker: match");
        end else begin
            $display("%0d mismatches, %0d results never came", mismatches,
                     pending_results.size());
            $display("outstanding_request_tracker: mismatch");
        end
        $finish;
    end

endmodule
